FILE: rtl/core/odo_pkg.sv
// Shared types, constants and the arctangent table of the odometry block.
package odo_pkg;

    localparam int unsigned DIV_W   = 40;   // divider dividend / quotient width
    localparam int unsigned DEN_W   = 13;   // divider divisor width
    localparam int unsigned MUL_W   = 64;   // multiplier accumulator width
    localparam int unsigned MB_W    = 32;   // multiplier operand width
    localparam int unsigned CRD_W   = 34;   // CORDIC datapath width

    localparam logic [11:0] TRACK_RESET  = 12'd112;
    localparam logic [9:0]  STEP_RESET   = 10'd100;
    localparam logic [MB_W-1:0] RAD_TO_BANG = 32'd683565;
    localparam logic signed [CRD_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] REG_TRACK = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LIN_DIV,
        ST_YAW_DIV,
        ST_MUL_YS,
        ST_MUL_YK,
        ST_LIN_ST,
        ST_DIST_DIV,
        ST_MUL_X,
        ST_MUL_Y,
        ST_OUT
    } odo_state_t;

    function automatic logic [31:0] atan_tab(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051D;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2E;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2F9;
            5'd15: v = 32'h0000517C;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A2F;
            5'd19: v = 32'h00000517;
            5'd20: v = 32'h0000028B;
            5'd21: v = 32'h00000145;
            5'd22: v = 32'h000000A2;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000028;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000002;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/diff_drive_odometry.sv
// Top level of the differential-drive odometry integrator.
//
// Each input beat carries the left and right wheel speeds (cm/s); the block
// returns one result beat with the updated pose (x, y in 2^-16 m, saturating;
// heading as a wrapping 32-bit binary angle) and the forward speed and yaw
// rate in Q16. Work per beat runs through three serial units: a restoring
// divider (three divisions: forward speed, yaw rate, step distance), a
// shift-add multiplier (one multiplier bit per cycle) and a CORDIC, which
// overlaps the distance computation. One beat is in flight at a time: the
// next may be accepted the cycle after the result register loads, and may
// be accepted while the previous result still waits in the output register.
// Registers are written through cfg_we/cfg_addr/cfg_wdata; the user must
// write them only while idle, and the block itself does not enforce it.
// Index 0 is the track width (mm, 0 acts as 1), index 1 the step time (ms),
// other indexes are ignored.
module diff_drive_odometry #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [11:0]  cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [31:0]  s_axis_tdata,   // left_speed[15:0], right_speed[31:16]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [191:0] m_axis_tdata    // pos_x[47:0], pos_y[95:48],
                                         // heading_angle[127:96],
                                         // linear_rate[153:128], yaw_rate[186:154]
);
    import odo_pkg::*;

    odo_state_t state_reg, state_next;
    logic go_reg, go_next;

    logic [11:0] track_reg;
    logic [9:0]  step_reg;
    logic signed [15:0] left_reg, right_reg;
    logic signed [25:0] lin_reg, lin_next;
    logic signed [32:0] yaw_reg, yaw_next;
    logic signed [27:0] dist_reg, dist_next;
    logic signed [MUL_W-1:0] prod_reg, prod_next;
    logic [31:0] head_reg, head_next;
    logic signed [47:0] x_reg, x_next, y_reg, y_next;
    logic div_neg_reg;

    logic m_valid_reg;
    logic [191:0] m_data_reg;

    // serial unit hookups
    logic div_start, div_done;
    logic [DIV_W-1:0] div_dividend, div_q;
    logic [DEN_W-1:0] div_den;
    logic signed [DIV_W:0] div_num, div_qs;
    logic mul_start, mul_done;
    logic signed [MUL_W-1:0] mul_a, mul_p;
    logic [MB_W-1:0] mul_b;
    logic [5:0] mul_n;
    logic crd_start, crd_done;
    logic signed [CRD_W-1:0] crd_cos, crd_sin;
    logic crd_seen_reg;

    logic [11:0] tw_eff;
    logic signed [16:0] sum_lr, diff_lr;
    logic signed [MUL_W-1:0] rnd_p, rnd_k;
    logic signed [48:0] pos_sum;
    logic out_load;

    assign tw_eff  = (track_reg == 12'd0) ? 12'd1 : track_reg;
    assign sum_lr  = 17'(left_reg) + 17'(right_reg);
    assign diff_lr = 17'(right_reg) - 17'(left_reg);

    // divider numerator and divisor per phase; floor of a negative quotient
    // comes from dividing ~N and inverting the result
    always_comb begin
        case (state_reg)
            ST_LIN_DIV: begin
                div_num = ((DIV_W+1)'(sum_lr) <<< 14) + (DIV_W+1)'(25);
                div_den = DEN_W'(50);
            end
            ST_YAW_DIV: begin
                div_num = ((DIV_W+1)'(diff_lr) <<< 20) + ((DIV_W+1)'(diff_lr) <<< 18)
                          + (DIV_W+1)'(signed'({1'b0, tw_eff}));
                div_den = {tw_eff, 1'b0};
            end
            ST_DIST_DIV: begin
                div_num = ((DIV_W+1)'(prod_reg) <<< 1) + (DIV_W+1)'(1000);
                div_den = DEN_W'(2000);
            end
            default: begin
                div_num = '0;
                div_den = DEN_W'(1);
            end
        endcase
    end

    assign div_dividend = div_num[DIV_W-1:0] ^ {DIV_W{div_num[DIV_W]}};
    assign div_start    = go_reg && (state_reg == ST_LIN_DIV || state_reg == ST_YAW_DIV
                                     || state_reg == ST_DIST_DIV);
    assign div_qs       = div_neg_reg ? ~signed'({1'b0, div_q}) : signed'({1'b0, div_q});

    // multiplier operands per phase
    always_comb begin
        case (state_reg)
            ST_MUL_YS: begin
                mul_a = MUL_W'(yaw_reg);
                mul_b = MB_W'(step_reg);
                mul_n = 6'd11;
            end
            ST_MUL_YK: begin
                mul_a = prod_reg;
                mul_b = RAD_TO_BANG;
                mul_n = 6'd21;
            end
            ST_LIN_ST: begin
                mul_a = MUL_W'(lin_reg);
                mul_b = MB_W'(step_reg);
                mul_n = 6'd11;
            end
            ST_MUL_X: begin
                mul_a = MUL_W'(crd_cos);
                mul_b = MB_W'(dist_reg);
                mul_n = 6'd28;
            end
            ST_MUL_Y: begin
                mul_a = MUL_W'(crd_sin);
                mul_b = MB_W'(dist_reg);
                mul_n = 6'd28;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
                mul_n = 6'd0;
            end
        endcase
    end

    assign mul_start = go_reg && (state_reg == ST_MUL_YS || state_reg == ST_MUL_YK
                                  || state_reg == ST_LIN_ST || state_reg == ST_MUL_X
                                  || state_reg == ST_MUL_Y);

    // CORDIC runs on the new heading alongside the distance computation
    // and is finished before the position products need it
    assign crd_start = go_reg && (state_reg == ST_LIN_ST);

    assign rnd_k   = mul_p + MUL_W'(64'sh8000);
    assign rnd_p   = (mul_p + MUL_W'(64'sh20000000)) >>> 30;
    assign pos_sum = (state_reg == ST_MUL_X) ? 49'(x_reg) + 49'(rnd_p)
                                             : 49'(y_reg) + 49'(rnd_p);

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign out_load      = (state_reg == ST_OUT) && (!m_valid_reg || m_axis_tready);

    always_comb begin
        state_next = state_reg;
        go_next    = 1'b0;
        lin_next   = lin_reg;
        yaw_next   = yaw_reg;
        dist_next  = dist_reg;
        prod_next  = prod_reg;
        head_next  = head_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    state_next = ST_LIN_DIV;
                    go_next    = 1'b1;
                end
            end
            ST_LIN_DIV: begin
                if (div_done) begin
                    lin_next   = div_qs[25:0];
                    state_next = ST_YAW_DIV;
                    go_next    = 1'b1;
                end
            end
            ST_YAW_DIV: begin
                if (div_done) begin
                    // saturate to the 33-bit range
                    if (div_qs[DIV_W:32] != {(DIV_W-31){div_qs[DIV_W]}})
                        yaw_next = div_qs[DIV_W] ? {1'b1, 32'h0} : {1'b0, {32{1'b1}}};
                    else
                        yaw_next = div_qs[32:0];
                    state_next = ST_MUL_YS;
                    go_next    = 1'b1;
                end
            end
            ST_MUL_YS: begin
                if (mul_done) begin
                    prod_next  = mul_p;
                    state_next = ST_MUL_YK;
                    go_next    = 1'b1;
                end
            end
            ST_MUL_YK: begin
                if (mul_done) begin
                    head_next  = head_reg + rnd_k[47:16];
                    state_next = ST_LIN_ST;
                    go_next    = 1'b1;
                end
            end
            ST_LIN_ST: begin
                if (mul_done) begin
                    prod_next  = mul_p;
                    state_next = ST_DIST_DIV;
                    go_next    = 1'b1;
                end
            end
            ST_DIST_DIV: begin
                // with the default CORDIC_STEPS the rotation ends first; advance only once it has
                if (div_done && crd_seen_reg) begin
                    dist_next  = div_qs[27:0];
                    state_next = ST_MUL_X;
                    go_next    = 1'b1;
                end
            end
            ST_MUL_X: begin
                if (mul_done) begin
                    if (pos_sum[48] != pos_sum[47])
                        x_next = pos_sum[48] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
                    else
                        x_next = pos_sum[47:0];
                    state_next = ST_MUL_Y;
                    go_next    = 1'b1;
                end
            end
            ST_MUL_Y: begin
                if (mul_done) begin
                    if (pos_sum[48] != pos_sum[47])
                        y_next = pos_sum[48] ? {1'b1, 47'h0} : {1'b0, {47{1'b1}}};
                    else
                        y_next = pos_sum[47:0];
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            go_reg      <= 1'b0;
            track_reg   <= TRACK_RESET;
            step_reg    <= STEP_RESET;
            head_reg    <= '0;
            x_reg       <= '0;
            y_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            go_reg    <= go_next;
            head_reg  <= head_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            if (cfg_we && cfg_addr == REG_TRACK) track_reg <= cfg_wdata;
            if (cfg_we && cfg_addr == REG_STEP)  step_reg  <= cfg_wdata[9:0];
            if (out_load)           m_valid_reg <= 1'b1;
            else if (m_axis_tready) m_valid_reg <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            left_reg  <= s_axis_tdata[15:0];
            right_reg <= s_axis_tdata[31:16];
        end
        if (div_start) div_neg_reg <= div_num[DIV_W];
        lin_reg  <= lin_next;
        yaw_reg  <= yaw_next;
        dist_reg <= dist_next;
        prod_reg <= prod_next;
        if (out_load)
            m_data_reg <= {5'd0, yaw_reg, lin_reg, head_reg, y_reg, x_reg};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    odo_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_den),
        .done     (div_done),
        .quotient (div_q)
    );

    odo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .mcand   (mul_a),
        .mplier  (mul_b),
        .nbits   (mul_n),
        .done    (mul_done),
        .product (mul_p)
    );

    odo_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (crd_start),
        .angle   (head_reg),
        .done    (crd_done),
        .cos_out (crd_cos),
        .sin_out (crd_sin)
    );

    // mark the rotation finished; its result holds until the next start
    always_ff @(posedge aclk) begin
        if (!aresetn)       crd_seen_reg <= 1'b0;
        else if (crd_start) crd_seen_reg <= 1'b0;
        else if (crd_done)  crd_seen_reg <= 1'b1;
    end

endmodule

FILE: rtl/core/odo_mul.sv
// Bit-serial signed shift-add multiplier, one multiplier bit per cycle.
module odo_mul (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [odo_pkg::MUL_W-1:0]   mcand,
    input  logic        [odo_pkg::MB_W-1:0]    mplier,
    input  logic        [5:0]                  nbits,
    output logic                               done,
    output logic signed [odo_pkg::MUL_W-1:0]   product
);
    import odo_pkg::*;

    logic signed [MUL_W-1:0] acc_reg, acc_next;
    logic signed [MUL_W-1:0] mcand_reg, mcand_next;
    logic [MB_W-1:0] mplier_reg, mplier_next;
    logic [5:0] cnt_reg, cnt_next;
    logic done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = '0;
            mcand_next  = mcand;
            mplier_next = mplier;
            cnt_next    = nbits;
        end else if (cnt_reg != 6'd0) begin
            // top bit of the multiplier carries negative weight
            if (mplier_reg[0]) begin
                if (cnt_reg == 6'd1) acc_next = acc_reg - mcand_reg;
                else                 acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = mcand_reg <<< 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 6'd1;
            done_next   = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

FILE: rtl/core/odo_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module odo_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [odo_pkg::DIV_W-1:0]   dividend,
    input  logic [odo_pkg::DEN_W-1:0]   divisor,
    output logic                        done,
    output logic [odo_pkg::DIV_W-1:0]   quotient
);
    import odo_pkg::*;

    logic [DIV_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [5:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic [DEN_W:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[DIV_W-1]};
        if (start) begin
            quo_next = dividend;
            rem_next = '0;
            den_next = divisor;
            cnt_next = 6'(DIV_W);
        end else if (cnt_reg != 6'd0) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[DIV_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next  = cnt_reg - 6'd1;
            done_next = (cnt_reg == 6'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

FILE: rtl/core/odo_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per cycle, half-turn folding.
module odo_cordic #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [31:0]                        angle,
    output logic                               done,
    output logic signed [odo_pkg::CRD_W-1:0]   cos_out,
    output logic signed [odo_pkg::CRD_W-1:0]   sin_out
);
    import odo_pkg::*;

    localparam int IW = $clog2(CORDIC_STEPS);

    logic signed [CRD_W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic signed [CRD_W-1:0] xs, ys, at;
    logic [IW-1:0] it_reg, it_next;
    logic busy_reg, busy_next, done_reg, done_next, flip_reg, flip_next;
    logic [31:0] ang_rot, ang_fold;

    always_comb begin
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        it_next   = it_reg;
        busy_next = busy_reg;
        flip_next = flip_reg;
        done_next = 1'b0;
        ang_rot   = angle + 32'h40000000;
        ang_fold  = ang_rot[31] ? angle + 32'h80000000 : angle;
        xs        = x_reg >>> it_reg;
        ys        = y_reg >>> it_reg;
        at        = CRD_W'(atan_tab(5'(it_reg)));
        if (start) begin
            flip_next = ang_rot[31];
            x_next    = CORDIC_GAIN;
            y_next    = '0;
            z_next    = CRD_W'(signed'(ang_fold));
            it_next   = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!z_reg[CRD_W-1]) begin
                x_next = x_reg - ys;
                y_next = y_reg + xs;
                z_next = z_reg - at;
            end else begin
                x_next = x_reg + ys;
                y_next = y_reg - xs;
                z_next = z_reg + at;
            end
            it_next = it_reg + 1'b1;
            if (it_reg == IW'(CORDIC_STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        it_reg   <= it_next;
        flip_reg <= flip_next;
    end

    assign done    = done_reg;
    assign cos_out = flip_reg ? -x_reg : x_reg;
    assign sin_out = flip_reg ? -y_reg : y_reg;

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench of the differential-drive odometry integrator.
module tb_top;
    import odo_pkg::*;

    localparam int STEPS       = 24;
    localparam int LATENCY     = 300;   // cycles from accepted beat to result, with margin
    localparam int IDLE_LIMIT  = 20000; // cycles without any beat before giving up
    localparam int RAND_ITEMS  = 1000;

    typedef struct packed {
        logic signed [15:0] right_speed;
        logic signed [15:0] left_speed;
    } wheel_beat_t;

    typedef struct {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic [31:0]        heading_angle;
        logic signed [25:0] linear_rate;
        logic signed [32:0] yaw_rate;
    } pose_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_addr;
    logic [11:0]  cfg_wdata;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [31:0]  s_axis_tdata;   // left_speed[15:0], right_speed[31:16]
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [191:0] m_axis_tdata;   // pos_x, pos_y, heading_angle, linear_rate, yaw_rate

    diff_drive_odometry #(.CORDIC_STEPS(STEPS)) dut (.*);

    // Predictor state and register copies
    logic [11:0]        pred_track;
    logic [9:0]         pred_step;
    logic [31:0]        pred_heading;
    logic signed [63:0] pred_x;
    logic signed [63:0] pred_y;

    wheel_beat_t pending_beats[$];
    pose_t       expected_poses[$];
    int          fail_count;
    int          idle_cycles;
    int          send_gap;
    int          recv_gap;
    int          hold_off;
    bit          stim_done;

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && ((a < 0) != (b < 0))) q--;
        return q;
    endfunction

    function automatic longint rdiv(longint n, longint d);
        return fdiv(2 * n + d, 2 * d);
    endfunction

    function automatic longint rshift(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint sat48(longint v);
        longint hi;
        hi = 64'sh7FFF_FFFF_FFFF;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic logic [31:0] atan_angle(int i);
        logic [31:0] tab[32];
        tab = '{32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
                32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
                32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
                32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
                32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
                32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
                32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
                32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000};
        return tab[i];
    endfunction

    // Rotation-mode CORDIC with half-turn flip into [-pi/2, pi/2)
    task automatic heading_cos_sin(input logic [31:0] ang, output longint c,
                                   output longint s);
        logic [31:0] a;
        bit          flip;
        longint      z, x, y, xs, ys;
        logic [31:0] t;
        flip = ((ang + 32'h4000_0000) & 32'h8000_0000) != 0;
        a = flip ? ang + 32'h8000_0000 : ang;
        z = longint'(signed'(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < (STEPS > 32 ? 32 : STEPS); i++) begin
            xs = x >>> i;
            ys = y >>> i;
            t = atan_angle(i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= longint'(t);
            end else begin
                x += ys; y -= xs; z += longint'(t);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // Advance the pose for one wheel-speed beat and queue the expected result
    task automatic integrate_pose(input wheel_beat_t b);
        longint l, r, tw, st, lin, yaw, dth, step_dist, c, s;
        pose_t  p;
        l = b.left_speed;
        r = b.right_speed;
        tw = (pred_track == 0) ? 1 : longint'(pred_track);
        st = pred_step;
        lin = rdiv((l + r) * 8192, 25);
        yaw = rdiv((r - l) * 655360, tw);
        if (yaw > 64'sh0_FFFF_FFFF) yaw = 64'sh0_FFFF_FFFF;
        if (yaw < -64'sh1_0000_0000) yaw = -64'sh1_0000_0000;
        dth = rshift(yaw * st * 683565, 16);
        pred_heading = pred_heading + dth[31:0];
        step_dist = rdiv(lin * st, 1000);
        heading_cos_sin(pred_heading, c, s);
        pred_x = sat48(pred_x + rshift(step_dist * c, 30));
        pred_y = sat48(pred_y + rshift(step_dist * s, 30));
        p.pos_x = pred_x[47:0];
        p.pos_y = pred_y[47:0];
        p.heading_angle = pred_heading;
        p.linear_rate = lin[25:0];
        p.yaw_rate = yaw[32:0];
        expected_poses.push_back(p);
    endtask

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Driver: offer queued beats, with a random gap before each one
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the beat until taken
        end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
            s_axis_tdata <= pending_beats.pop_front();
            s_axis_tvalid <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // Predict on every accepted input beat
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            integrate_pose(wheel_beat_t'(s_axis_tdata));
    end

    // Monitor: random ready stalls, a long hold-off when asked, field checks
    always @(posedge aclk) begin
        pose_t exp_p;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_poses.size() == 0) begin
                    $error("result beat with nothing expected");
                    fail_count++;
                end else begin
                    exp_p = expected_poses.pop_front();
                    if (m_axis_tdata[47:0] !== exp_p.pos_x) begin
                        $error("pos_x expected %0d got %0d", exp_p.pos_x,
                               $signed(m_axis_tdata[47:0]));
                        fail_count++;
                    end
                    if (m_axis_tdata[95:48] !== exp_p.pos_y) begin
                        $error("pos_y expected %0d got %0d", exp_p.pos_y,
                               $signed(m_axis_tdata[95:48]));
                        fail_count++;
                    end
                    if (m_axis_tdata[127:96] !== exp_p.heading_angle) begin
                        $error("heading_angle expected %0h got %0h",
                               exp_p.heading_angle, m_axis_tdata[127:96]);
                        fail_count++;
                    end
                    if (m_axis_tdata[153:128] !== exp_p.linear_rate) begin
                        $error("linear_rate expected %0d got %0d", exp_p.linear_rate,
                               $signed(m_axis_tdata[153:128]));
                        fail_count++;
                    end
                    if (m_axis_tdata[186:154] !== exp_p.yaw_rate) begin
                        $error("yaw_rate expected %0d got %0d", exp_p.yaw_rate,
                               $signed(m_axis_tdata[186:154]));
                        fail_count++;
                    end
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                // draw the stall before the next result
                recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog: count cycles in which no beat moves on either side
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready)
            || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (!stim_done) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        if (idx == REG_TRACK) pred_track = val;
        else if (idx == REG_STEP) pred_step = val[9:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_beat(input int l, input int r);
        wheel_beat_t b;
        b.left_speed = l[15:0];
        b.right_speed = r[15:0];
        pending_beats.push_back(b);
    endtask

    // Drain everything in flight, then let the block settle before a write
    task automatic drain();
        while (pending_beats.size() > 0 || s_axis_tvalid || expected_poses.size() > 0)
            @(posedge aclk);
        repeat (LATENCY) @(posedge aclk);
    endtask

    // Mostly moderate speeds so the pose stays meaningful, some full-range beats
    task automatic random_beats(input int n);
        int l, r;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: begin
                    l = $signed(16'($urandom));
                    r = $signed(16'($urandom));
                end
                1: begin
                    l = $urandom_range(0, 400) - 200;
                    r = l;
                end
                default: begin
                    l = $urandom_range(0, 2000) - 1000;
                    r = $urandom_range(0, 2000) - 1000;
                end
            endcase
            send_beat(l, r);
        end
    endtask

    initial begin
        logic [11:0] tracks[6];
        logic [9:0]  steps[6];
        tracks = '{12'd112, 12'd10, 12'd4095, 12'd0, 12'd3, 12'd500};
        steps  = '{10'd100, 10'd1, 10'd1000, 10'd0, 10'd1023, 10'd37};
        fail_count = 0;
        stim_done = 0;
        hold_off = 0;
        pred_track = TRACK_RESET;
        pred_step = STEP_RESET;
        pred_heading = '0;
        pred_x = 0;
        pred_y = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        s_axis_tdata = '0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: speed extremes, turning in place, straight runs, at reset config
        send_beat(0, 0);
        send_beat(32767, 32767);
        send_beat(-32768, -32768);
        send_beat(-32768, 32767);
        send_beat(32767, -32768);
        send_beat(100, -100);
        send_beat(-1, 1);
        send_beat(1, 0);
        send_beat(-200, -200);
        send_beat(50, 150);
        drain();

        // Unknown register index: ignored
        write_reg(2'd2, 12'hFFF);
        write_reg(2'd3, 12'h5A5);
        send_beat(300, 200);
        send_beat(-32768, 32767);
        drain();

        // Long receiver hold-off while the sender keeps offering beats
        hold_off = 400;
        random_beats(8);
        drain();

        // Sweep register settings, extremes included (zero track, short track,
        // zero step time, max step)
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_TRACK, tracks[k]);
            write_reg(REG_STEP, {2'b0, steps[k]});
            send_beat(32767, -32768);
            send_beat(1000, 1000);
            random_beats(RAND_ITEMS / 6);
            drain();
        end

        stim_done = 1;
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
